>>> sv/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, codes and reset values for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int IDX_W          = 4;
    localparam int PHASE_W        = 3;
    localparam int GESTURE_W      = 3;

    // Register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 4'd0;
    localparam logic [IDX_W-1:0] REG_MEDIUM   = 4'd1;
    localparam logic [IDX_W-1:0] REG_GAP      = 4'd2;
    localparam logic [IDX_W-1:0] REG_LONG     = 4'd3;

    // Reset values of the thresholds
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] MEDIUM_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] GAP_RST      = 16'd100;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd4000;

    // Gesture phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HELD     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_GAP      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LONGHOLD = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RELEASE  = 3'd5;

    // Gesture codes
    localparam logic [GESTURE_W-1:0] G_NONE   = 3'd0;
    localparam logic [GESTURE_W-1:0] G_SHORT  = 3'd1;
    localparam logic [GESTURE_W-1:0] G_DOUBLE = 3'd2;
    localparam logic [GESTURE_W-1:0] G_MEDIUM = 3'd3;
    localparam logic [GESTURE_W-1:0] G_LONG   = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] medium_ticks;
        logic [CFG_W-1:0] gap_ticks;
        logic [CFG_W-1:0] long_ticks;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        debounce_ticks: DEBOUNCE_RST,
        medium_ticks:   MEDIUM_RST,
        gap_ticks:      GAP_RST,
        long_ticks:     LONG_RST
    };

endpackage

>>> sv/bpc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_step
// Next-state and gesture logic for one button sample.
// ----------------------------------------------------------------------------
module bpc_step
    import bpc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic [PHASE_W-1:0]    phase,
    input  logic [TIMER_BITS-1:0] stamp,
    input  logic                  pressed,
    input  logic [TIMER_BITS-1:0] time_now,
    input  cfg_t                  cfg,
    output logic [PHASE_W-1:0]    phase_next,
    output logic [TIMER_BITS-1:0] stamp_next,
    output logic [GESTURE_W-1:0]  gesture
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic [TIMER_BITS-1:0] elapsed;
    logic [CMP_W-1:0]      elapsed_x;
    logic                  over_debounce;
    logic                  over_medium;
    logic                  over_gap;
    logic                  over_long;

    // modulo 2^TIMER_BITS, so timer wrap is harmless
    assign elapsed   = time_now - stamp;
    assign elapsed_x = CMP_W'(elapsed);

    assign over_debounce = elapsed_x > CMP_W'(cfg.debounce_ticks);
    assign over_medium   = elapsed_x > CMP_W'(cfg.medium_ticks);
    assign over_gap      = elapsed_x > CMP_W'(cfg.gap_ticks);
    assign over_long     = elapsed_x > CMP_W'(cfg.long_ticks);

    always_comb
    begin
        phase_next = phase;
        stamp_next = stamp;
        gesture    = G_NONE;
        case (phase)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next = PH_DEBOUNCE;
                    stamp_next = time_now;
                end
            end
            PH_DEBOUNCE:
            begin
                if (!pressed)
                    phase_next = PH_IDLE;
                else if (over_debounce)
                    phase_next = PH_HELD;
            end
            PH_HELD:
            begin
                if (!pressed)
                begin
                    phase_next = PH_GAP;
                    stamp_next = time_now;
                end
                else if (over_medium)
                    phase_next = PH_LONGHOLD;
            end
            PH_GAP:
            begin
                if (pressed)
                begin
                    gesture    = G_DOUBLE;
                    phase_next = PH_RELEASE;
                end
                else if (over_gap)
                begin
                    gesture    = G_SHORT;
                    phase_next = PH_IDLE;
                end
            end
            PH_LONGHOLD:
            begin
                if (!pressed)
                begin
                    gesture    = G_MEDIUM;
                    phase_next = PH_IDLE;
                end
                else if (over_long)
                begin
                    gesture    = G_LONG;
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                if (!pressed)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

>>> sv/button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier
// Classifies polled button samples into short, double, medium and long
// presses; one result transaction per sample.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  s_axis   | in        | s_tvalid / s_tready    | s_tdata: pressed, time_now
//  m_axis   | out       | m_tvalid / m_tready    | m_tdata: gesture
//  cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One sample per clock while s_tready is high. The step (subtract, four
//  compares, phase update) sits between the phase/stamp registers and the
//  result register, so a gesture shows in the cycle after its sample.
//  s_tready is high whenever the result register is empty or is being
//  drained in the same cycle; a stall on m_tready stalls the input only
//  while the held result is still waiting.
//  Reset (rst_n low, asynchronous) sets the phase to idle, the stamp to
//  zero, the thresholds to their defaults and empties the result register.
//  cfg_ready is always high; writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // sample stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [0] pressed, [TIMER_BITS:1] time_now, zero fill above
    input  logic [((TIMER_BITS+1+7)/8)*8-1:0]       s_tdata,
    // gesture stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [2:0] gesture, zero fill above
    output logic [7:0]                              m_tdata,
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [IDX_W-1:0]                        cfg_index,
    input  logic [CFG_W-1:0]                        cfg_data
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [TIMER_BITS-1:0] stamp_reg;
    logic [TIMER_BITS-1:0] stamp_next;
    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [GESTURE_W-1:0]  gesture_reg;
    logic [GESTURE_W-1:0]  gesture_next;

    logic                  s_accept;
    logic                  m_accept;
    logic                  pressed;
    logic [TIMER_BITS-1:0] time_now;
    logic [GESTURE_W-1:0]  step_gesture;

    // field unpack
    assign pressed  = s_tdata[0];
    assign time_now = s_tdata[TIMER_BITS:1];

    // result register doubles as the skid: free, or emptying this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = out_valid_reg && m_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(8-GESTURE_W){1'b0}}, gesture_reg};
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Gesture step
    // ------------------------------------------------------------------
    bpc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .phase      (phase_reg),
        .stamp      (stamp_reg),
        .pressed    (pressed),
        .time_now   (time_now),
        .cfg        (cfg_reg),
        .phase_next (phase_next),
        .stamp_next (stamp_next),
        .gesture    (step_gesture)
    );

    // ------------------------------------------------------------------
    // Next-value logic
    // ------------------------------------------------------------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_next.debounce_ticks = cfg_data;
                REG_MEDIUM:   cfg_next.medium_ticks   = cfg_data;
                REG_GAP:      cfg_next.gap_ticks      = cfg_data;
                REG_LONG:     cfg_next.long_ticks     = cfg_data;
                default:      cfg_next                = cfg_reg;  // unknown index ignored
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        gesture_next   = gesture_reg;
        if (s_accept)
        begin
            out_valid_next = 1'b1;
            gesture_next   = step_gesture;
        end
        else if (m_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            stamp_reg     <= '0;
            cfg_reg       <= CFG_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
            if (s_accept)
            begin
                phase_reg <= phase_next;
                stamp_reg <= stamp_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        gesture_reg <= gesture_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_RELEASE)
        else $error("phase register holds an unused code");

    a_gesture_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (gesture_reg <= G_LONG))
        else $error("gesture code out of range");

    a_release_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && phase_reg == PH_RELEASE && !pressed) |=> phase_reg == PH_IDLE)
        else $error("release sample did not return to idle");

    a_quiet_phases: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && phase_reg != PH_GAP && phase_reg != PH_LONGHOLD)
        |=> gesture_reg == G_NONE)
        else $error("gesture reported from a phase that cannot end a press");

endmodule
